// ===== rtl/core/priority_round_robin_task_scheduler_assert.svh =====
// Assertion macros for the task scheduler RTL.
// Define NO_ASSERTIONS to compile the checks out; clocked on clk, gated by rst_n.
`ifndef PRIORITY_ROUND_ROBIN_TASK_SCHEDULER_ASSERT_SVH
`define PRIORITY_ROUND_ROBIN_TASK_SCHEDULER_ASSERT_SVH
`ifndef NO_ASSERTIONS
`define PRRS_ASSERT_IMPLY(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) else $error(msg);
`define PRRS_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) else $error(msg);
`else
`define PRRS_ASSERT_IMPLY(lbl, ante, cons, msg)
`define PRRS_ASSERT_NEXT(lbl, ante, cons, msg)
`endif
`endif

// ===== rtl/core/prrs_pkg.sv =====
// Shared types and constants of the task scheduler.
// No dependencies; imported by the controller, datapath and top level.
`timescale 1ns / 1ps
package prrs_pkg;

  typedef enum logic [3:0] {
    OP_TICK    = 4'd0,
    OP_SCHED   = 4'd1,
    OP_CREATE  = 4'd2,
    OP_EXIT    = 4'd3,
    OP_BLOCK   = 4'd4,
    OP_UNBLOCK = 4'd5,
    OP_SLEEP   = 4'd6,
    OP_YIELD   = 4'd7,
    OP_SETPRIO = 4'd8,
    OP_FREE    = 4'd9
  } op_t;

  typedef enum logic [2:0] {
    SST_FREE    = 3'd0,
    SST_READY   = 3'd1,
    SST_RUNNING = 3'd2,
    SST_BLOCKED = 3'd3,
    SST_ZOMBIE  = 3'd4
  } sst_t;

  localparam logic [1:0] STAT_OK     = 2'd0;
  localparam logic [1:0] STAT_NOSLOT = 2'd1;
  localparam logic [1:0] STAT_BAD    = 2'd2;

  localparam logic [1:0] REG_SLICE_IDLE     = 2'd0;
  localparam logic [1:0] REG_SLICE_NORMAL   = 2'd1;
  localparam logic [1:0] REG_SLICE_HIGH     = 2'd2;
  localparam logic [1:0] REG_SLICE_REALTIME = 2'd3;

  localparam logic [7:0] SLICE_IDLE_RST     = 8'd2;
  localparam logic [7:0] SLICE_NORMAL_RST   = 8'd10;
  localparam logic [7:0] SLICE_HIGH_RST     = 8'd20;
  localparam logic [7:0] SLICE_REALTIME_RST = 8'd30;

  // ceil(ms / 10) = ((ms + 9) * DIV10_MUL) >> DIV10_SHIFT, exact below 2^18
  localparam logic [16:0] MS_ROUND    = 17'd9;
  localparam logic [33:0] DIV10_MUL   = 34'd104858;
  localparam int          DIV10_SHIFT = 20;
  localparam int          QW          = 13;

  typedef enum logic [4:0] {
    CMD_NONE,
    CMD_LOAD,
    CMD_TICK_INC,
    CMD_WAKE_CHK,
    CMD_FREE_CHK,
    CMD_APPEND,
    CMD_UNLINK,
    CMD_ST_BAD,
    CMD_EXIT,
    CMD_BLOCK,
    CMD_UNBLOCK,
    CMD_SETPRIO,
    CMD_SLICE0,
    CMD_DIV,
    CMD_SLEEP_WR,
    CMD_FREE_MARK,
    CMD_FREE_CLR,
    CMD_ROT,
    CMD_PRE_INIT,
    CMD_PRE_STEP,
    CMD_RDY_NEXT,
    CMD_RDY_HEAD,
    CMD_RDY_STEP,
    CMD_COMMIT,
    CMD_HAND,
    CMD_OUT
  } dp_cmd_t;

  typedef struct packed {
    logic [3:0] op;
    logic       good;
    logic       slot_zero;
    logic       slot_blocked;
    logic       slot_zombie;
    logic       slot_is_run;
    logic       run_zero;
    logic       ms_zero;
    logic       rot_move;
    logic       cur_keep;
    logic       pre_end;
    logic       rdy_end;
    logic       idx_free;
    logic       idx_last;
    logic       out_hold;
  } dp_stat_t;

endpackage

// ===== rtl/core/prrs_datapath.sv =====
// Scheduler datapath: slot table, run queue links, scan pointers and result register.
// Depends on prrs_pkg and the assertion macro header; driven by prrs_ctrl commands.
`timescale 1ns / 1ps
`include "priority_round_robin_task_scheduler_assert.svh"
module prrs_datapath #(
  parameter int TASK_SLOTS = 16
) (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               cfg_we,
  input  logic [1:0]         cfg_index,
  input  logic [7:0]         cfg_data,
  input  logic [3:0]         in_opcode,
  input  logic [3:0]         in_task_slot,
  input  logic [1:0]         in_priority_in,
  input  logic [15:0]        in_sleep_ms,
  input  prrs_pkg::dp_cmd_t  cmd,
  output prrs_pkg::dp_stat_t stat,
  input  logic               out_stall,
  output logic               out_valid,
  output logic [1:0]         out_status,
  output logic [3:0]         out_current_slot,
  output logic               out_switched,
  output logic [3:0]         out_previous_slot,
  output logic [3:0]         out_created_slot
);
  import prrs_pkg::*;

  localparam int SW = $clog2(TASK_SLOTS);
  localparam int LW = SW + 1;
  localparam int CW = $clog2(TASK_SLOTS + 1);

  typedef logic [LW-1:0] link_t;
  localparam link_t NIL = {LW{1'b1}};

  function automatic logic [7:0] fix_slice(input logic [7:0] v);
    return (v == 8'd0) ? 8'd1 : v;
  endfunction

  // Slot table and queue
  logic [7:0]    cfg_r [4];
  sst_t          st_r  [TASK_SLOTS];
  logic [1:0]    pr_r  [TASK_SLOTS];
  logic [7:0]    sl_r  [TASK_SLOTS];
  logic [31:0]   wk_r  [TASK_SLOTS];
  link_t         nx_r  [TASK_SLOTS];
  link_t         pv_r  [TASK_SLOTS];
  link_t         head_r, tail_r;
  logic [SW-1:0] run_r;
  logic [31:0]   tick_r;

  // Per-command work registers
  logic [3:0]    op_r;
  logic [3:0]    slot_r;
  logic [1:0]    pin_r;
  logic [15:0]   ms_r;
  logic [SW-1:0] prev_r, cur_r, tgt_r, n_r, idx_r, created_r;
  logic [1:0]    status_r;
  link_t         it_r, start_r;
  logic [CW-1:0] cnt_r;
  logic [QW-1:0] q_r;

  logic          out_valid_r;
  logic [1:0]    out_status_r;
  logic [3:0]    out_cur_r, out_prev_r, out_created_r;
  logic          out_sw_r;

  logic [SW-1:0] sidx, itx, tx, px, nxx, ptx;
  logic          slot_ok, good;
  link_t         tlink, it2, rdy_start;
  logic          pre_live, pre_hit, rdy_live, rdy_hit, rdy_stop;
  logic [33:0]   prod;
  logic [31:0]   wake_sum, wake_diff;
  logic [16:0]   ms_up;

  // Decode and scan conditions
  assign sidx    = SW'(slot_r);
  assign slot_ok = (32'(slot_r) < 32'(TASK_SLOTS));
  assign good    = slot_ok && (st_r[sidx] != SST_FREE);
  assign itx     = it_r[SW-1:0];
  assign tx      = tgt_r;
  assign tlink   = {1'b0, tgt_r};
  assign px      = pv_r[tx][SW-1:0];
  assign nxx     = nx_r[tx][SW-1:0];
  assign ptx     = tail_r[SW-1:0];

  assign pre_live = (cnt_r < CW'(TASK_SLOTS)) && !it_r[LW-1];
  assign pre_hit  = pre_live && (itx != cur_r) && (st_r[itx] == SST_READY) &&
                    (pr_r[itx] > pr_r[cur_r]);
  assign it2      = nx_r[itx][LW-1] ? head_r : nx_r[itx];
  assign rdy_live = (cnt_r < CW'(TASK_SLOTS)) && !it_r[LW-1];
  assign rdy_hit  = rdy_live && (st_r[itx] == SST_READY);
  assign rdy_stop = !rdy_live || (it2 == start_r) || (cnt_r == CW'(TASK_SLOTS - 1));
  assign rdy_start = nx_r[cur_r][LW-1] ? head_r : nx_r[cur_r];

  assign ms_up     = {1'b0, ms_r} + MS_ROUND;
  assign prod      = 34'(ms_up) * DIV10_MUL;
  assign wake_sum  = tick_r + 32'(q_r);
  assign wake_diff = tick_r - wk_r[idx_r];

  // Status toward the controller
  always_comb begin
    stat.op           = op_r;
    stat.good         = good;
    stat.slot_zero    = (slot_r == 4'd0);
    stat.slot_blocked = (st_r[sidx] == SST_BLOCKED);
    stat.slot_zombie  = (st_r[sidx] == SST_ZOMBIE);
    stat.slot_is_run  = slot_ok && (sidx == run_r);
    stat.run_zero     = (run_r == '0);
    stat.ms_zero      = (ms_r == 16'd0);
    stat.rot_move     = (st_r[run_r] == SST_RUNNING) && (sl_r[run_r] == 8'd0) &&
                        !nx_r[run_r][LW-1];
    stat.cur_keep     = (st_r[cur_r] == SST_RUNNING) && (sl_r[cur_r] != 8'd0);
    stat.pre_end      = pre_hit || !pre_live;
    stat.rdy_end      = rdy_hit || rdy_stop;
    stat.idx_free     = (st_r[idx_r] == SST_FREE);
    stat.idx_last     = (idx_r == SW'(TASK_SLOTS - 1));
    stat.out_hold     = out_valid_r && out_stall;
  end

  // Configuration registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r[REG_SLICE_IDLE]     <= SLICE_IDLE_RST;
      cfg_r[REG_SLICE_NORMAL]   <= SLICE_NORMAL_RST;
      cfg_r[REG_SLICE_HIGH]     <= SLICE_HIGH_RST;
      cfg_r[REG_SLICE_REALTIME] <= SLICE_REALTIME_RST;
    end else if (cfg_we) begin
      cfg_r[cfg_index] <= cfg_data;
    end
  end

  // Execute one command per cycle
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      for (int i = 0; i < TASK_SLOTS; i++) begin
        st_r[i] <= SST_FREE;
        pr_r[i] <= 2'd0;
        sl_r[i] <= 8'd0;
        wk_r[i] <= 32'd0;
        nx_r[i] <= NIL;
        pv_r[i] <= NIL;
      end
      st_r[0]     <= SST_RUNNING;
      sl_r[0]     <= SLICE_IDLE_RST;
      head_r      <= '0;
      tail_r      <= '0;
      run_r       <= '0;
      tick_r      <= 32'd0;
      out_valid_r <= 1'b0;
    end else begin
      // Drop the result once taken, unless a new one loads this cycle
      if (out_valid_r && !out_stall && cmd != CMD_OUT) begin
        out_valid_r <= 1'b0;
      end
      case (cmd)
        CMD_LOAD: begin
          op_r      <= in_opcode;
          slot_r    <= in_task_slot;
          pin_r     <= in_priority_in;
          ms_r      <= in_sleep_ms;
          prev_r    <= run_r;
          status_r  <= STAT_OK;
          created_r <= '0;
          idx_r     <= '0;
        end
        CMD_TICK_INC: begin
          tick_r <= tick_r + 32'd1;
          idx_r  <= '0;
          if (st_r[run_r] == SST_RUNNING && sl_r[run_r] != 8'd0) begin
            sl_r[run_r] <= sl_r[run_r] - 8'd1;
          end
        end
        CMD_WAKE_CHK: begin
          if (st_r[idx_r] == SST_BLOCKED && wk_r[idx_r] != 32'd0 && !wake_diff[31]) begin
            wk_r[idx_r] <= 32'd0;
            st_r[idx_r] <= SST_READY;
            sl_r[idx_r] <= fix_slice(cfg_r[pr_r[idx_r]]);
          end
          idx_r <= idx_r + SW'(1);
        end
        CMD_FREE_CHK: begin
          if (st_r[idx_r] == SST_FREE) begin
            st_r[idx_r] <= SST_READY;
            pr_r[idx_r] <= pin_r;
            sl_r[idx_r] <= fix_slice(cfg_r[pin_r]);
            wk_r[idx_r] <= 32'd0;
            created_r   <= idx_r;
            tgt_r       <= idx_r;
          end else if (idx_r == SW'(TASK_SLOTS - 1)) begin
            status_r <= STAT_NOSLOT;
          end
          idx_r <= idx_r + SW'(1);
        end
        CMD_APPEND: begin
          nx_r[tx] <= NIL;
          if (head_r[LW-1] || tail_r[LW-1]) begin
            head_r   <= tlink;
            pv_r[tx] <= NIL;
          end else begin
            pv_r[tx]  <= tail_r;
            nx_r[ptx] <= tlink;
          end
          tail_r <= tlink;
        end
        CMD_UNLINK: begin
          if (!pv_r[tx][LW-1]) nx_r[px] <= nx_r[tx];
          else head_r <= nx_r[tx];
          if (!nx_r[tx][LW-1]) pv_r[nxx] <= pv_r[tx];
          else tail_r <= pv_r[tx];
          nx_r[tx] <= NIL;
          pv_r[tx] <= NIL;
        end
        CMD_ST_BAD: status_r <= STAT_BAD;
        CMD_EXIT: begin
          st_r[run_r] <= SST_ZOMBIE;
          tgt_r       <= run_r;
        end
        CMD_BLOCK: st_r[sidx] <= SST_BLOCKED;
        CMD_UNBLOCK: begin
          if (st_r[sidx] == SST_BLOCKED) begin
            st_r[sidx] <= SST_READY;
            sl_r[sidx] <= fix_slice(cfg_r[pr_r[sidx]]);
            wk_r[sidx] <= 32'd0;
          end
        end
        CMD_SETPRIO: begin
          pr_r[sidx] <= pin_r;
          sl_r[sidx] <= fix_slice(cfg_r[pin_r]);
        end
        CMD_SLICE0: sl_r[run_r] <= 8'd0;
        CMD_DIV: q_r <= prod[DIV10_SHIFT +: QW];
        CMD_SLEEP_WR: begin
          wk_r[run_r] <= (wake_sum == 32'd0) ? 32'd1 : wake_sum;
          st_r[run_r] <= SST_BLOCKED;
        end
        CMD_FREE_MARK: begin
          st_r[sidx] <= SST_ZOMBIE;
          tgt_r      <= sidx;
        end
        CMD_FREE_CLR: begin
          st_r[sidx] <= SST_FREE;
          pr_r[sidx] <= 2'd0;
          sl_r[sidx] <= 8'd0;
          wk_r[sidx] <= 32'd0;
          nx_r[sidx] <= NIL;
          pv_r[sidx] <= NIL;
        end
        CMD_ROT: begin
          cur_r <= run_r;
          tgt_r <= run_r;
          if (st_r[run_r] == SST_RUNNING && sl_r[run_r] == 8'd0) begin
            st_r[run_r] <= SST_READY;
            sl_r[run_r] <= fix_slice(cfg_r[pr_r[run_r]]);
          end
        end
        CMD_PRE_INIT: begin
          it_r  <= head_r;
          cnt_r <= '0;
        end
        CMD_PRE_STEP: begin
          if (pre_hit) n_r <= itx;
          else if (!pre_live) n_r <= cur_r;
          else begin
            it_r  <= nx_r[itx];
            cnt_r <= cnt_r + CW'(1);
          end
        end
        CMD_RDY_NEXT: begin
          it_r    <= rdy_start;
          start_r <= rdy_start;
          cnt_r   <= '0;
        end
        CMD_RDY_HEAD: begin
          it_r    <= head_r;
          start_r <= head_r;
          cnt_r   <= '0;
        end
        CMD_RDY_STEP: begin
          if (rdy_hit) n_r <= itx;
          else if (rdy_stop) n_r <= '0;
          else begin
            it_r  <= it2;
            cnt_r <= cnt_r + CW'(1);
          end
        end
        CMD_COMMIT: begin
          if (n_r == cur_r) begin
            st_r[cur_r] <= SST_RUNNING;
          end else begin
            if (st_r[cur_r] == SST_RUNNING) st_r[cur_r] <= SST_READY;
            st_r[n_r] <= SST_RUNNING;
            if (sl_r[n_r] == 8'd0) sl_r[n_r] <= fix_slice(cfg_r[pr_r[n_r]]);
            run_r <= n_r;
          end
        end
        CMD_HAND: begin
          st_r[n_r] <= SST_RUNNING;
          sl_r[n_r] <= fix_slice(cfg_r[pr_r[n_r]]);
          run_r     <= n_r;
        end
        CMD_OUT: begin
          out_valid_r   <= 1'b1;
          out_status_r  <= status_r;
          out_cur_r     <= 4'(run_r);
          out_sw_r      <= (run_r != prev_r);
          out_prev_r    <= 4'(prev_r);
          out_created_r <= 4'(created_r);
        end
        default: ;
      endcase
    end
  end

  assign out_valid         = out_valid_r;
  assign out_status        = out_status_r;
  assign out_current_slot  = out_cur_r;
  assign out_switched      = out_sw_r;
  assign out_previous_slot = out_prev_r;
  assign out_created_slot  = out_created_r;

  `PRRS_ASSERT_IMPLY(a_run_is_running, cmd == CMD_LOAD, st_r[run_r] == SST_RUNNING, "running slot not in running state")
  `PRRS_ASSERT_IMPLY(a_queue_nonempty, cmd == CMD_LOAD, !head_r[LW-1] && !tail_r[LW-1], "run queue lost its head or tail")
  `PRRS_ASSERT_IMPLY(a_out_free, cmd == CMD_OUT, !(out_valid_r && out_stall), "result overwritten while stalled")

endmodule

// ===== rtl/core/prrs_ctrl.sv =====
// Scheduler controller: sequences one command through datapath micro-steps.
// Depends on prrs_pkg; talks to prrs_datapath through dp_cmd_t and dp_stat_t.
`timescale 1ns / 1ps
module prrs_ctrl (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               in_valid,
  output logic               in_stall,
  input  prrs_pkg::dp_stat_t stat,
  output prrs_pkg::dp_cmd_t  cmd
);
  import prrs_pkg::*;

  typedef enum logic [17:0] {
    S_IDLE    = 18'h00001,
    S_DISP    = 18'h00002,
    S_WAKE    = 18'h00004,
    S_FSCAN   = 18'h00008,
    S_NEWAPP  = 18'h00010,
    S_UNLINK  = 18'h00020,
    S_HINIT   = 18'h00040,
    S_HAND    = 18'h00080,
    S_SLPWR   = 18'h00100,
    S_FREECLR = 18'h00200,
    S_ROT     = 18'h00400,
    S_ROTUL   = 18'h00800,
    S_ROTAP   = 18'h01000,
    S_PICK    = 18'h02000,
    S_PSTEP   = 18'h04000,
    S_RSTEP   = 18'h08000,
    S_COMMIT  = 18'h10000,
    S_DONE    = 18'h20000
  } state_t;

  state_t state_r, state_nxt;
  logic   hand_r, hand_nxt;
  logic   free_r, free_nxt;

  assign in_stall = (state_r != S_IDLE);

  // Next state and datapath command
  always_comb begin
    state_nxt = state_r;
    hand_nxt  = hand_r;
    free_nxt  = free_r;
    cmd       = CMD_NONE;
    case (state_r)
      S_IDLE: begin
        if (in_valid) begin
          cmd       = CMD_LOAD;
          state_nxt = S_DISP;
        end
      end
      S_DISP: begin
        free_nxt = 1'b0;
        hand_nxt = 1'b0;
        case (stat.op)
          OP_TICK: begin
            cmd       = CMD_TICK_INC;
            state_nxt = S_WAKE;
          end
          OP_SCHED: state_nxt = S_ROT;
          OP_CREATE: state_nxt = S_FSCAN;
          OP_EXIT: begin
            if (stat.run_zero) begin
              cmd       = CMD_ST_BAD;
              state_nxt = S_DONE;
            end else begin
              cmd       = CMD_EXIT;
              state_nxt = S_UNLINK;
            end
          end
          OP_BLOCK: begin
            if (!stat.good || stat.slot_zero || stat.slot_zombie) begin
              cmd       = CMD_ST_BAD;
              state_nxt = S_DONE;
            end else if (stat.slot_blocked) begin
              state_nxt = S_DONE;
            end else begin
              cmd       = CMD_BLOCK;
              state_nxt = stat.slot_is_run ? S_ROT : S_DONE;
            end
          end
          OP_UNBLOCK: begin
            cmd       = stat.good ? CMD_UNBLOCK : CMD_ST_BAD;
            state_nxt = S_DONE;
          end
          OP_SLEEP: begin
            if (stat.ms_zero) begin
              cmd       = CMD_SLICE0;
              state_nxt = S_ROT;
            end else if (stat.run_zero) begin
              cmd       = CMD_ST_BAD;
              state_nxt = S_DONE;
            end else begin
              cmd       = CMD_DIV;
              state_nxt = S_SLPWR;
            end
          end
          OP_YIELD: begin
            cmd       = CMD_SLICE0;
            state_nxt = S_ROT;
          end
          OP_SETPRIO: begin
            cmd       = stat.good ? CMD_SETPRIO : CMD_ST_BAD;
            state_nxt = S_DONE;
          end
          OP_FREE: begin
            free_nxt = 1'b1;
            if (!stat.good || stat.slot_zero) begin
              cmd       = CMD_ST_BAD;
              state_nxt = S_DONE;
            end else if (stat.slot_zombie) begin
              state_nxt = S_FREECLR;
            end else begin
              cmd       = CMD_FREE_MARK;
              state_nxt = S_UNLINK;
            end
          end
          default: state_nxt = S_DONE;
        endcase
      end
      // Wake sleepers, one slot a cycle
      S_WAKE: begin
        cmd = CMD_WAKE_CHK;
        if (stat.idx_last) state_nxt = S_DONE;
      end
      // Find the lowest free slot
      S_FSCAN: begin
        cmd = CMD_FREE_CHK;
        if (stat.idx_free) state_nxt = S_NEWAPP;
        else if (stat.idx_last) state_nxt = S_DONE;
      end
      S_NEWAPP: begin
        cmd       = CMD_APPEND;
        state_nxt = S_DONE;
      end
      S_UNLINK: begin
        cmd       = CMD_UNLINK;
        state_nxt = (free_r && !stat.slot_is_run) ? S_FREECLR : S_HINIT;
      end
      S_HINIT: begin
        cmd       = CMD_RDY_HEAD;
        hand_nxt  = 1'b1;
        state_nxt = S_RSTEP;
      end
      S_HAND: begin
        cmd       = CMD_HAND;
        hand_nxt  = 1'b0;
        state_nxt = S_ROT;
      end
      S_SLPWR: begin
        cmd       = CMD_SLEEP_WR;
        state_nxt = S_ROT;
      end
      S_FREECLR: begin
        cmd       = CMD_FREE_CLR;
        state_nxt = S_DONE;
      end
      // Rotate an exhausted running task to the tail
      S_ROT: begin
        cmd       = CMD_ROT;
        state_nxt = stat.rot_move ? S_ROTUL : S_PICK;
      end
      S_ROTUL: begin
        cmd       = CMD_UNLINK;
        state_nxt = S_ROTAP;
      end
      S_ROTAP: begin
        cmd       = CMD_APPEND;
        state_nxt = S_PICK;
      end
      S_PICK: begin
        if (stat.cur_keep) begin
          cmd       = CMD_PRE_INIT;
          state_nxt = S_PSTEP;
        end else begin
          cmd       = CMD_RDY_NEXT;
          state_nxt = S_RSTEP;
        end
      end
      S_PSTEP: begin
        cmd = CMD_PRE_STEP;
        if (stat.pre_end) state_nxt = S_COMMIT;
      end
      S_RSTEP: begin
        cmd = CMD_RDY_STEP;
        if (stat.rdy_end) state_nxt = hand_r ? S_HAND : S_COMMIT;
      end
      S_COMMIT: begin
        cmd       = CMD_COMMIT;
        state_nxt = free_r ? S_FREECLR : S_DONE;
      end
      // Hand the result to the output register once it is free
      S_DONE: begin
        if (!stat.out_hold) begin
          cmd       = CMD_OUT;
          state_nxt = S_IDLE;
        end
      end
      default: state_nxt = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
      hand_r  <= 1'b0;
      free_r  <= 1'b0;
    end else begin
      state_r <= state_nxt;
      hand_r  <= hand_nxt;
      free_r  <= free_nxt;
    end
  end

endmodule

// ===== rtl/core/priority_round_robin_task_scheduler.sv =====
// Priority-preemptive round-robin task scheduler, top level.
// Input channel: in_valid/in_stall carry one command item (opcode, slot, priority, sleep ms).
// Result channel: out_valid/out_stall carry one result item per command.
// Configuration: cfg_we writes slice register cfg_index (0 idle .. 3 realtime) with cfg_data.
// One command is worked at a time; in_stall is high from acceptance until its result
// is loaded into the output register. The output register frees the input side, so a
// new command is taken while the previous result still waits downstream.
// From acceptance to out_valid: commands that touch one slot act in the dispatch step;
// tick walks the slot table one slot per cycle, create scans for the lowest free slot
// and appends it; commands that reschedule walk the run queue one link per cycle, and
// free or exit of the running task walks it twice, once to hand over and once to pick.
// The next item is taken in the cycle after a result loads.
// Reset (synchronous, rst_n low): idle task in slot 0 running, all other slots free,
// slice registers back to 2/10/20/30, no result pending.
// When out_stall holds a result, the next finished command waits in its last step
// until the output register is taken.
`timescale 1ns / 1ps
module priority_round_robin_task_scheduler #(
  parameter int TASK_SLOTS = 16
) (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        cfg_we,
  input  logic [1:0]  cfg_index,
  input  logic [7:0]  cfg_data,
  input  logic        in_valid,
  output logic        in_stall,
  input  logic [3:0]  in_opcode,
  input  logic [3:0]  in_task_slot,
  input  logic [1:0]  in_priority_in,
  input  logic [15:0] in_sleep_ms,
  output logic        out_valid,
  input  logic        out_stall,
  output logic [1:0]  out_status,
  output logic [3:0]  out_current_slot,
  output logic        out_switched,
  output logic [3:0]  out_previous_slot,
  output logic [3:0]  out_created_slot
);
  import prrs_pkg::*;

  dp_cmd_t  cmd;
  dp_stat_t stat;

  prrs_ctrl u_ctrl (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_valid),
    .in_stall (in_stall),
    .stat     (stat),
    .cmd      (cmd)
  );

  prrs_datapath #(
    .TASK_SLOTS (TASK_SLOTS)
  ) u_dp (
    .clk               (clk),
    .rst_n             (rst_n),
    .cfg_we            (cfg_we),
    .cfg_index         (cfg_index),
    .cfg_data          (cfg_data),
    .in_opcode         (in_opcode),
    .in_task_slot      (in_task_slot),
    .in_priority_in    (in_priority_in),
    .in_sleep_ms       (in_sleep_ms),
    .cmd               (cmd),
    .stat              (stat),
    .out_stall         (out_stall),
    .out_valid         (out_valid),
    .out_status        (out_status),
    .out_current_slot  (out_current_slot),
    .out_switched      (out_switched),
    .out_previous_slot (out_previous_slot),
    .out_created_slot  (out_created_slot)
  );

endmodule

// ===== tb/tb.sv =====
// Testbench for the priority round-robin task scheduler: directed table, then random commands.
// Depends on prrs_pkg and the priority_round_robin_task_scheduler top level only.
`timescale 1ns / 1ps
module tb;
  import prrs_pkg::*;

  localparam int          SLOTS   = 16;
  localparam logic [7:0]  NO_LINK = 8'hFF;
  localparam int          DRAIN   = 60;

  typedef struct {
    logic [1:0] status;
    logic [3:0] cur;
    logic       sw;
    logic [3:0] prv;
    logic [3:0] crt;
  } sched_res_t;

  typedef struct {
    logic [3:0]  op;
    logic [3:0]  slot;
    logic [1:0]  prio;
    logic [15:0] ms;
    bit          typed;
    sched_res_t  want;
  } cmd_row_t;

  logic        clk;
  logic        rst_n;
  logic        cfg_we;
  logic [1:0]  cfg_index;
  logic [7:0]  cfg_data;
  logic        in_valid;
  logic        in_stall;
  logic [3:0]  in_opcode;
  logic [3:0]  in_task_slot;
  logic [1:0]  in_priority_in;
  logic [15:0] in_sleep_ms;
  logic        out_valid;
  logic        out_stall;
  logic [1:0]  out_status;
  logic [3:0]  out_current_slot;
  logic        out_switched;
  logic [3:0]  out_previous_slot;
  logic [3:0]  out_created_slot;

  // Scheduler shadow state
  logic [7:0]  slice_reg [4];
  sst_t        t_state   [SLOTS];
  logic [1:0]  t_prio    [SLOTS];
  logic [7:0]  t_slice   [SLOTS];
  logic [31:0] t_wake    [SLOTS];
  logic [7:0]  t_next    [SLOTS];
  logic [7:0]  t_prev    [SLOTS];
  logic [7:0]  q_head, q_tail, run_slot;
  logic [31:0] tick_cnt;

  sched_res_t  pending_res [$];
  int          err_count;
  int          cmd_count;
  int          res_count;
  bit          in_idle_on;
  bit          out_idle_on;

  priority_round_robin_task_scheduler #(.TASK_SLOTS(SLOTS)) DUT (
    .clk(clk), .rst_n(rst_n),
    .cfg_we(cfg_we), .cfg_index(cfg_index), .cfg_data(cfg_data),
    .in_valid(in_valid), .in_stall(in_stall),
    .in_opcode(in_opcode), .in_task_slot(in_task_slot),
    .in_priority_in(in_priority_in), .in_sleep_ms(in_sleep_ms),
    .out_valid(out_valid), .out_stall(out_stall),
    .out_status(out_status), .out_current_slot(out_current_slot),
    .out_switched(out_switched), .out_previous_slot(out_previous_slot),
    .out_created_slot(out_created_slot)
  );

  initial begin
    clk = 1'b0;
    forever #4 clk = ~clk;
  end

  initial begin
    #5_000_000;
    $display("FAIL priority_round_robin_task_scheduler");
    $finish;
  end

  function automatic bit is_slot(logic [7:0] s);
    return s < SLOTS;
  endfunction

  function automatic logic [7:0] fresh_slice(logic [1:0] p);
    return (slice_reg[p] == 8'd0) ? 8'd1 : slice_reg[p];
  endfunction

  function automatic void q_remove(logic [7:0] s);
    logic [7:0] p, n;
    p = t_prev[s];
    n = t_next[s];
    if (is_slot(p)) t_next[p] = n; else q_head = n;
    if (is_slot(n)) t_prev[n] = p; else q_tail = p;
    t_next[s] = NO_LINK;
    t_prev[s] = NO_LINK;
  endfunction

  function automatic void q_push(logic [7:0] s);
    t_next[s] = NO_LINK;
    t_prev[s] = q_tail;
    if (!is_slot(q_head) || !is_slot(q_tail)) begin
      q_head = s;
      t_prev[s] = NO_LINK;
    end else begin
      t_next[q_tail] = s;
    end
    q_tail = s;
  endfunction

  // First ready slot from start, wrapping round the run queue
  function automatic logic [7:0] first_ready(logic [7:0] start);
    logic [7:0] it;
    it = is_slot(start) ? start : q_head;
    start = it;
    for (int i = 0; i < SLOTS && is_slot(it); i++) begin
      if (t_state[it] == SST_READY) return it;
      it = t_next[it];
      if (!is_slot(it)) it = q_head;
      if (it == start) break;
    end
    return NO_LINK;
  endfunction

  function automatic logic [7:0] choose_next(logic [7:0] cur);
    logic [7:0] it, r;
    if (t_state[cur] == SST_RUNNING && t_slice[cur] > 0) begin
      it = q_head;
      for (int i = 0; i < SLOTS && is_slot(it); i++) begin
        if (it != cur && t_state[it] == SST_READY && t_prio[it] > t_prio[cur]) return it;
        it = t_next[it];
      end
      return cur;
    end
    r = first_ready(t_next[cur]);
    if (is_slot(r)) return r;
    if (t_state[0] != SST_RUNNING) t_state[0] = SST_READY;
    return 8'd0;
  endfunction

  function automatic void resched();
    logic [7:0] cur, n;
    cur = run_slot;
    if (t_state[cur] == SST_RUNNING && t_slice[cur] == 0) begin
      t_state[cur] = SST_READY;
      t_slice[cur] = fresh_slice(t_prio[cur]);
      if (is_slot(t_next[cur])) begin
        q_remove(cur);
        q_push(cur);
      end
    end
    n = choose_next(cur);
    if (n == cur) begin
      t_state[cur] = SST_RUNNING;
      return;
    end
    if (t_state[cur] == SST_RUNNING) t_state[cur] = SST_READY;
    t_state[n] = SST_RUNNING;
    if (t_slice[n] == 0) t_slice[n] = fresh_slice(t_prio[n]);
    run_slot = n;
  endfunction

  // Running task left the queue: head ready task (or idle) takes over
  function automatic void take_over();
    logic [7:0] n;
    n = first_ready(q_head);
    if (!is_slot(n)) n = 8'd0;
    t_state[n] = SST_RUNNING;
    t_slice[n] = fresh_slice(t_prio[n]);
    run_slot = n;
    resched();
  endfunction

  function automatic void sched_reset();
    slice_reg[0] = SLICE_IDLE_RST;
    slice_reg[1] = SLICE_NORMAL_RST;
    slice_reg[2] = SLICE_HIGH_RST;
    slice_reg[3] = SLICE_REALTIME_RST;
    for (int i = 0; i < SLOTS; i++) begin
      t_state[i] = SST_FREE;
      t_prio[i]  = 2'd0;
      t_slice[i] = 8'd0;
      t_wake[i]  = 32'd0;
      t_next[i]  = NO_LINK;
      t_prev[i]  = NO_LINK;
    end
    t_state[0] = SST_RUNNING;
    t_slice[0] = slice_reg[0];
    q_head = 8'd0;
    q_tail = 8'd0;
    run_slot = 8'd0;
    tick_cnt = 32'd0;
  endfunction

  // Apply one command to the shadow state and return the expected result
  function automatic sched_res_t run_command(logic [3:0] op, logic [3:0] slot_in,
                                             logic [1:0] prio, logic [15:0] ms);
    sched_res_t r;
    logic [7:0]  prv, s;
    logic [31:0] w, diff;
    bit          good;
    s = {4'd0, slot_in};
    prv = run_slot;
    r.status = STAT_OK;
    r.crt = 4'd0;
    good = (t_state[s] != SST_FREE);
    case (op)
      OP_TICK: begin
        tick_cnt = tick_cnt + 1;
        if (t_state[run_slot] == SST_RUNNING && t_slice[run_slot] > 0)
          t_slice[run_slot] = t_slice[run_slot] - 1;
        for (int i = 0; i < SLOTS; i++) begin
          diff = tick_cnt - t_wake[i];
          if (t_state[i] == SST_BLOCKED && t_wake[i] != 0 && !diff[31]) begin
            t_wake[i] = 32'd0;
            t_state[i] = SST_READY;
            t_slice[i] = fresh_slice(t_prio[i]);
          end
        end
      end
      OP_SCHED: resched();
      OP_CREATE: begin
        r.status = STAT_NOSLOT;
        for (int i = 0; i < SLOTS; i++) begin
          if (t_state[i] == SST_FREE) begin
            t_state[i] = SST_READY;
            t_prio[i]  = prio;
            t_slice[i] = fresh_slice(prio);
            t_wake[i]  = 32'd0;
            q_push(i[7:0]);
            r.status = STAT_OK;
            r.crt = i[3:0];
            break;
          end
        end
      end
      OP_EXIT: begin
        if (run_slot == 0) r.status = STAT_BAD;
        else begin
          t_state[run_slot] = SST_ZOMBIE;
          q_remove(run_slot);
          take_over();
        end
      end
      OP_BLOCK: begin
        if (!good || s == 0 || t_state[s] == SST_ZOMBIE) r.status = STAT_BAD;
        else if (t_state[s] != SST_BLOCKED) begin
          t_state[s] = SST_BLOCKED;
          if (s == run_slot) resched();
        end
      end
      OP_UNBLOCK: begin
        if (!good) r.status = STAT_BAD;
        else if (t_state[s] == SST_BLOCKED) begin
          t_state[s] = SST_READY;
          t_slice[s] = fresh_slice(t_prio[s]);
          t_wake[s]  = 32'd0;
        end
      end
      OP_SLEEP: begin
        if (ms == 0) begin
          t_slice[run_slot] = 8'd0;
          resched();
        end else if (run_slot == 0) begin
          r.status = STAT_BAD;
        end else begin
          w = tick_cnt + (32'(ms) + 32'd9) / 32'd10;
          t_wake[run_slot] = (w == 0) ? 32'd1 : w;
          t_state[run_slot] = SST_BLOCKED;
          resched();
        end
      end
      OP_YIELD: begin
        t_slice[run_slot] = 8'd0;
        resched();
      end
      OP_SETPRIO: begin
        if (!good) r.status = STAT_BAD;
        else begin
          t_prio[s]  = prio;
          t_slice[s] = fresh_slice(prio);
        end
      end
      OP_FREE: begin
        if (!good || s == 0) r.status = STAT_BAD;
        else begin
          if (t_state[s] != SST_ZOMBIE) begin
            q_remove(s);
            t_state[s] = SST_ZOMBIE;
            if (s == run_slot) take_over();
          end
          t_state[s] = SST_FREE;
          t_prio[s]  = 2'd0;
          t_slice[s] = 8'd0;
          t_wake[s]  = 32'd0;
          t_next[s]  = NO_LINK;
          t_prev[s]  = NO_LINK;
        end
      end
      default: ;
    endcase
    r.cur = run_slot[3:0];
    r.sw  = (run_slot != prv);
    r.prv = prv[3:0];
    return r;
  endfunction

  task automatic report_mismatch(string what, int got, int want);
    $display("mismatch at result %0d: %s got %0d expected %0d", res_count, what, got, want);
    err_count++;
  endtask

  // Present one command item, hold it until taken, then log its expected result
  task automatic send_cmd(logic [3:0] op, logic [3:0] slot, logic [1:0] prio,
                          logic [15:0] ms, bit typed, sched_res_t want);
    sched_res_t r;
    if (in_idle_on && $urandom_range(99) < 34) begin
      in_valid <= 1'b0;
      @(posedge clk);
      while ($urandom_range(99) < 34) @(posedge clk);
    end
    in_valid       <= 1'b1;
    in_opcode      <= op;
    in_task_slot   <= slot;
    in_priority_in <= prio;
    in_sleep_ms    <= ms;
    @(posedge clk);
    while (in_stall) @(posedge clk);
    r = run_command(op, slot, prio, ms);
    pending_res.push_back(typed ? want : r);
    cmd_count++;
  endtask

  // Wait for all results and the block to settle, then rewrite the slice registers
  task automatic set_slices(logic [7:0] v0, logic [7:0] v1, logic [7:0] v2, logic [7:0] v3);
    logic [7:0] vals [4];
    vals = '{v0, v1, v2, v3};
    in_valid <= 1'b0;
    while (pending_res.size() != 0) @(posedge clk);
    repeat (DRAIN) @(posedge clk);
    for (int i = 0; i < 4; i++) begin
      cfg_we    <= 1'b1;
      cfg_index <= i[1:0];
      cfg_data  <= vals[i];
      slice_reg[i] = vals[i];
      @(posedge clk);
    end
    cfg_we <= 1'b0;
  endtask

  task automatic random_cmds(int count);
    logic [3:0]  op;
    logic [15:0] ms;
    int          r;
    sched_res_t  none;
    none = '{default: '0};
    for (int k = 0; k < count; k++) begin
      r = $urandom_range(99);
      if (r < 20)      op = OP_TICK;
      else if (r < 30) op = OP_SCHED;
      else if (r < 42) op = OP_CREATE;
      else if (r < 48) op = OP_EXIT;
      else if (r < 56) op = OP_BLOCK;
      else if (r < 64) op = OP_UNBLOCK;
      else if (r < 72) op = OP_SLEEP;
      else if (r < 80) op = OP_YIELD;
      else if (r < 87) op = OP_SETPRIO;
      else if (r < 96) op = OP_FREE;
      else             op = 4'($urandom_range(10, 15));
      r = $urandom_range(99);
      if (r < 10)      ms = 16'd0;
      else if (r < 80) ms = 16'($urandom_range(1, 60));
      else if (r < 95) ms = 16'($urandom_range(1, 1000));
      else             ms = 16'($urandom);
      send_cmd(op, 4'($urandom), 2'($urandom), ms, 1'b0, none);
    end
  endtask

  // Result channel: check each taken item, stall at random
  always @(posedge clk) begin
    sched_res_t e;
    if (rst_n && out_valid && !out_stall) begin
      if (pending_res.size() == 0) begin
        report_mismatch("unexpected item, status", out_status, 0);
      end else begin
        e = pending_res.pop_front();
        if (out_status !== e.status) report_mismatch("status", out_status, e.status);
        if (out_current_slot !== e.cur) report_mismatch("current_slot", out_current_slot, e.cur);
        if (out_switched !== e.sw) report_mismatch("switched", out_switched, e.sw);
        if (out_previous_slot !== e.prv)
          report_mismatch("previous_slot", out_previous_slot, e.prv);
        if (out_created_slot !== e.crt)
          report_mismatch("created_slot", out_created_slot, e.crt);
      end
      res_count++;
    end
    out_stall <= out_idle_on && ($urandom_range(99) < 34);
  end

  cmd_row_t dir_rows [] = '{
    // after reset: tick, refused exit / block / free / unblock / sleep on idle or free slots, then a create
    '{OP_TICK,    4'd0,  2'd0, 16'd0,     1, '{STAT_OK,  4'd0, 1'b0, 4'd0, 4'd0}},
    '{OP_EXIT,    4'd0,  2'd0, 16'd0,     1, '{STAT_BAD, 4'd0, 1'b0, 4'd0, 4'd0}},
    '{OP_BLOCK,   4'd0,  2'd0, 16'd0,     1, '{STAT_BAD, 4'd0, 1'b0, 4'd0, 4'd0}},
    '{OP_FREE,    4'd5,  2'd0, 16'd0,     1, '{STAT_BAD, 4'd0, 1'b0, 4'd0, 4'd0}},
    '{OP_UNBLOCK, 4'd15, 2'd3, 16'd0,     1, '{STAT_BAD, 4'd0, 1'b0, 4'd0, 4'd0}},
    '{OP_SLEEP,   4'd0,  2'd0, 16'd5,     1, '{STAT_BAD, 4'd0, 1'b0, 4'd0, 4'd0}},
    '{OP_CREATE,  4'd0,  2'd1, 16'd0,     1, '{STAT_OK,  4'd0, 1'b0, 4'd0, 4'd1}},
    // higher priority ready task preempts idle
    '{OP_SCHED,   4'd0,  2'd0, 16'd0,     1, '{STAT_OK,  4'd1, 1'b1, 4'd0, 4'd0}},
    '{OP_CREATE,  4'd0,  2'd3, 16'd0,     0, '{default: '0}},
    '{OP_CREATE,  4'd0,  2'd2, 16'd0,     0, '{default: '0}},
    '{OP_CREATE,  4'd0,  2'd0, 16'd0,     0, '{default: '0}},
    '{OP_SCHED,   4'd0,  2'd0, 16'd0,     0, '{default: '0}},
    '{OP_BLOCK,   4'd2,  2'd0, 16'd0,     0, '{default: '0}},
    '{OP_BLOCK,   4'd2,  2'd0, 16'd0,     0, '{default: '0}},
    '{OP_SLEEP,   4'd0,  2'd0, 16'd0,     0, '{default: '0}},
    '{OP_SLEEP,   4'd0,  2'd0, 16'hFFFF,  0, '{default: '0}},
    '{OP_YIELD,   4'd0,  2'd0, 16'd0,     0, '{default: '0}},
    '{OP_SETPRIO, 4'd4,  2'd3, 16'd0,     0, '{default: '0}},
    '{OP_UNBLOCK, 4'd2,  2'd0, 16'd0,     0, '{default: '0}},
    '{OP_UNBLOCK, 4'd1,  2'd0, 16'd0,     0, '{default: '0}},
    '{OP_EXIT,    4'd0,  2'd0, 16'd0,     0, '{default: '0}},
    '{OP_FREE,    4'd3,  2'd0, 16'd0,     0, '{default: '0}},
    '{OP_BLOCK,   4'd4,  2'd0, 16'd0,     0, '{default: '0}},
    '{4'd15,      4'd15, 2'd3, 16'hFFFF,  0, '{default: '0}},
    '{4'd10,      4'd8,  2'd2, 16'd10,    0, '{default: '0}}
  };

  initial begin
    rst_n          <= 1'b0;
    cfg_we         <= 1'b0;
    cfg_index      <= REG_SLICE_IDLE;
    cfg_data       <= 8'd0;
    in_valid       <= 1'b0;
    in_opcode      <= OP_TICK;
    in_task_slot   <= 4'd0;
    in_priority_in <= 2'd0;
    in_sleep_ms    <= 16'd0;
    out_stall      <= 1'b0;
    err_count   = 0;
    cmd_count   = 0;
    res_count   = 0;
    in_idle_on  = 1'b1;
    out_idle_on = 1'b1;
    sched_reset();
    repeat (11) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    foreach (dir_rows[i])
      send_cmd(dir_rows[i].op, dir_rows[i].slot, dir_rows[i].prio, dir_rows[i].ms,
               dir_rows[i].typed, dir_rows[i].want);
    random_cmds(300);

    // shortest slices, zero treated as one
    set_slices(8'd0, 8'd1, 8'd1, 8'd1);
    random_cmds(320);

    // longest slices, no idling on either side
    set_slices(8'd255, 8'd255, 8'd255, 8'd255);
    in_idle_on  = 1'b0;
    out_idle_on = 1'b0;
    random_cmds(320);
    in_idle_on  = 1'b1;
    out_idle_on = 1'b1;

    set_slices(8'($urandom_range(1, 8)), 8'($urandom_range(1, 8)),
               8'($urandom_range(1, 8)), 8'($urandom_range(1, 8)));
    random_cmds(320);

    in_valid <= 1'b0;
    while (pending_res.size() != 0) @(posedge clk);
    repeat (DRAIN) @(posedge clk);

    $display("run covered %0d commands, %0d results checked, four slice settings",
             cmd_count, res_count);
    if (err_count == 0) begin
      $display("PASS priority_round_robin_task_scheduler");
    end else begin
      $display("FAIL priority_round_robin_task_scheduler");
    end
    $finish;
  end

endmodule

// ===== priority_round_robin_task_scheduler.f =====
+incdir+rtl/core
rtl/core/prrs_pkg.sv
rtl/core/prrs_datapath.sv
rtl/core/prrs_ctrl.sv
rtl/core/priority_round_robin_task_scheduler.sv
tb/tb.sv
